// ===== design/ptt_pkg.sv =====
// Shared types and codes for the periodic timer table.
// Used by ptt_cell and periodic_timer_table_core; depends on nothing.
package ptt_pkg;

    localparam int ENTRIES_DEF    = 8;
    localparam int COUNT_BITS_DEF = 16;

    localparam int HID_W     = 8;
    localparam int SLOT_W    = 3;
    localparam int IN_CNT_W  = 16;
    localparam int IDX_OUT_W = 3;
    localparam int FLAG_W    = 5;

    localparam int FL_LOADED    = 0;
    localparam int FL_RUNNABLE  = 1;
    localparam int FL_SUSPENDED = 2;
    localparam int FL_ONESHOT   = 3;
    localparam int FL_DELETED   = 4;

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_DISPATCH = 3'd1,
        MODE_SUSPEND  = 3'd2,
        MODE_RESUME   = 3'd3,
        MODE_RESET    = 3'd4,
        MODE_LOAD     = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        KIND_ACK     = 3'd0,
        KIND_FIRED   = 3'd1,
        KIND_NONE    = 3'd2,
        KIND_FOUND   = 3'd3,
        KIND_INVALID = 3'd4
    } t_kind;

    typedef struct packed {
        logic                tick;
        logic                load;
        logic                start;
        logic                advance;
        logic                halt;
        logic                fire_upd;
        logic                srch_upd;
        t_mode               mode;
        logic [HID_W-1:0]    hid;
        logic [SLOT_W-1:0]   slot;
        logic [IN_CNT_W-1:0] period;
        logic [IN_CNT_W-1:0] sdelay;
        logic                single_shot;
    } t_cell_ctl;

    typedef struct packed {
        logic             tok;
        logic             fire;
        logic             match;
        logic [HID_W-1:0] handler;
    } t_cell_sts;

endpackage

// ===== design/ptt_cell.sv =====
// One timer entry of the table, with its place in the scan token chain.
// Depends on ptt_pkg.
module ptt_cell #(
    parameter int COUNT_BITS = ptt_pkg::COUNT_BITS_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptt_pkg::t_cell_ctl  i_ctl,
    input  logic                i_prev_tok,
    output ptt_pkg::t_cell_sts  o_sts
);
    import ptt_pkg::*;

    logic [FLAG_W-1:0]     r_flags, n_flags;
    logic [COUNT_BITS-1:0] r_delay, n_delay;
    logic [COUNT_BITS-1:0] r_intv, n_intv;
    logic [HID_W-1:0]      r_hdl, n_hdl;
    logic                  r_tok, n_tok;

    always_comb begin
        n_flags = r_flags;
        n_delay = r_delay;
        n_intv  = r_intv;
        n_hdl   = r_hdl;
        n_tok   = r_tok;
        if (i_ctl.tick && r_flags[FL_RUNNABLE] && (r_delay != '0)) begin
            n_delay = r_delay - COUNT_BITS'(1);
        end
        if (i_ctl.load && (32'(i_ctl.slot) == CELL_IDX)) begin
            n_hdl   = i_ctl.hid;
            n_intv  = COUNT_BITS'(i_ctl.period);
            n_delay = COUNT_BITS'(i_ctl.sdelay);
            n_flags = '0;
            n_flags[FL_LOADED]   = 1'b1;
            n_flags[FL_RUNNABLE] = 1'b1;
            n_flags[FL_ONESHOT]  = i_ctl.single_shot;
        end
        if (i_ctl.fire_upd && r_tok) begin
            if (r_flags[FL_ONESHOT]) begin
                n_delay = '0;
                n_flags = '0;
                n_flags[FL_DELETED] = 1'b1;
            end else begin
                n_delay = r_intv;
            end
        end
        if (i_ctl.srch_upd && r_tok) begin
            case (i_ctl.mode)
                MODE_SUSPEND: begin
                    n_flags[FL_RUNNABLE]  = 1'b0;
                    n_flags[FL_SUSPENDED] = 1'b1;
                end
                MODE_RESUME: begin
                    n_flags[FL_RUNNABLE]  = 1'b1;
                    n_flags[FL_SUSPENDED] = 1'b0;
                end
                MODE_RESET: begin
                    n_delay = r_intv;
                    n_flags[FL_RUNNABLE]  = 1'b1;
                    n_flags[FL_SUSPENDED] = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (i_ctl.start) begin
            n_tok = (CELL_IDX == 0);
        end else if (i_ctl.halt) begin
            n_tok = 1'b0;
        end else if (i_ctl.advance) begin
            n_tok = i_prev_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_tok   <= 1'b0;
        end else begin
            r_flags <= n_flags;
            r_tok   <= n_tok;
        end
        r_delay <= n_delay;
        r_intv  <= n_intv;
        r_hdl   <= n_hdl;
    end

    assign o_sts.tok     = r_tok;
    assign o_sts.fire    = r_flags[FL_RUNNABLE] && (r_delay == '0);
    assign o_sts.match   = r_flags[FL_LOADED] && (r_hdl == i_ctl.hid);
    assign o_sts.handler = r_hdl;

endmodule

// ===== design/periodic_timer_table_core.sv =====
// Periodic timer table: top level with the scan controller and the cell row.
// Depends on ptt_pkg and ptt_cell.
//
//  channel | dir | tdata (low bit up)                                   | tuser | tlast
//  s       | in  | handler_id[7:0] slot[10:8] period[26:11]             | mode  |  -
//          |     | start_delay[42:27] single_shot[43], zero pad to 48   |       |
//  m       | out | found_index[2:0] fired_handler[10:3], zero pad to 16 | kind  | last
//
// Tick, load and invalid words: the result is registered as the word is taken.
// Dispatch: a token walks the cell row one cell per cycle, holding while a fire
// result waits on the output. Suspend, resume and reset: the token walks to the
// first matching cell or the last cell. One word is taken at a time, once the scan
// is over and the result register is empty or being read. Reset is synchronous.
module periodic_timer_table_core #(
    parameter int ENTRIES    = ptt_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = ptt_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // handler_id, slot, period, start_delay, single_shot
    input  logic [2:0]  i_s_tuser,   // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // found_index, fired_handler
    output logic [2:0]  o_m_tuser,   // kind
    output logic        o_m_tlast    // last
);
    import ptt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {S_IDLE, S_DISP, S_FLUSH, S_SRCH} t_state;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    t_mode                  r_mode, n_mode;
    logic [HID_W-1:0]       r_id, n_id;
    logic                   r_pend_v, n_pend_v;
    logic [IDX_OUT_W-1:0]   r_pend_idx, n_pend_idx;
    logic [HID_W-1:0]       r_pend_hdl, n_pend_hdl;
    logic                   r_m_valid, n_m_valid;
    t_kind                  r_m_kind, n_m_kind;
    logic [IDX_OUT_W-1:0]   r_m_idx, n_m_idx;
    logic [HID_W-1:0]       r_m_hdl, n_m_hdl;
    logic                   r_m_last, n_m_last;

    t_cell_ctl              w_ctl;
    t_cell_sts              w_sts [ENTRIES];
    logic [ENTRIES-1:0]     w_tok;
    logic                   w_fire, w_match, w_out_free, w_acc, w_last_cell;
    logic [HID_W-1:0]       w_hdl;
    t_mode                  w_in_mode;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            logic w_prev;
            if (g == 0) begin : g_first
                assign w_prev = 1'b0;
            end else begin : g_next
                assign w_prev = w_tok[g-1];
            end
            ptt_cell #(
                .COUNT_BITS (COUNT_BITS),
                .CELL_IDX   (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_prev_tok (w_prev),
                .o_sts      (w_sts[g])
            );
            assign w_tok[g] = w_sts[g].tok;
        end
    endgenerate

    always_comb begin
        w_fire  = 1'b0;
        w_match = 1'b0;
        w_hdl   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_fire  = w_fire  | (w_sts[i].tok & w_sts[i].fire);
            w_match = w_match | (w_sts[i].tok & w_sts[i].match);
            w_hdl   = w_hdl   | ({HID_W{w_sts[i].tok}} & w_sts[i].handler);
        end
    end

    assign w_in_mode   = t_mode'(i_s_tuser);
    assign w_out_free  = !r_m_valid || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE) && w_out_free;
    assign w_acc       = i_s_tvalid && o_s_tready;
    assign w_last_cell = (r_idx == IDX_W'(ENTRIES - 1));

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_mode     = r_mode;
        n_id       = r_id;
        n_pend_v   = r_pend_v;
        n_pend_idx = r_pend_idx;
        n_pend_hdl = r_pend_hdl;
        n_m_valid  = r_m_valid && !i_m_tready;
        n_m_kind   = r_m_kind;
        n_m_idx    = r_m_idx;
        n_m_hdl    = r_m_hdl;
        n_m_last   = r_m_last;

        w_ctl             = '0;
        w_ctl.mode        = r_mode;
        w_ctl.hid         = (r_state == S_IDLE) ? i_s_tdata[7:0] : r_id;
        w_ctl.slot        = i_s_tdata[10:8];
        w_ctl.period      = i_s_tdata[26:11];
        w_ctl.sdelay      = i_s_tdata[42:27];
        w_ctl.single_shot = i_s_tdata[43];

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_m_kind = KIND_INVALID;
                    n_m_idx  = '0;
                    n_m_hdl  = '0;
                    n_m_last = 1'b1;
                    n_mode   = w_in_mode;
                    n_id     = i_s_tdata[7:0];
                    n_idx    = '0;
                    case (w_in_mode)
                        MODE_TICK: begin
                            w_ctl.tick = 1'b1;
                            n_m_valid  = 1'b1;
                            n_m_kind   = KIND_ACK;
                        end
                        MODE_LOAD: begin
                            n_m_valid = 1'b1;
                            if (32'(i_s_tdata[10:8]) < ENTRIES) begin
                                w_ctl.load = 1'b1;
                                n_m_kind   = KIND_ACK;
                                n_m_idx    = i_s_tdata[10:8];
                            end
                        end
                        MODE_DISPATCH: begin
                            w_ctl.start = 1'b1;
                            n_pend_v    = 1'b0;
                            n_state     = S_DISP;
                        end
                        MODE_SUSPEND, MODE_RESUME, MODE_RESET: begin
                            w_ctl.start = 1'b1;
                            n_state     = S_SRCH;
                        end
                        default: begin
                            n_m_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_DISP: begin
                if (!w_fire || !r_pend_v || w_out_free) begin
                    w_ctl.advance = 1'b1;
                    n_idx = r_idx + IDX_W'(1);
                    if (w_fire) begin
                        w_ctl.fire_upd = 1'b1;
                        if (r_pend_v) begin
                            n_m_valid = 1'b1;
                            n_m_kind  = KIND_FIRED;
                            n_m_idx   = r_pend_idx;
                            n_m_hdl   = r_pend_hdl;
                            n_m_last  = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_idx = IDX_OUT_W'(r_idx);
                        n_pend_hdl = w_hdl;
                    end
                    if (w_last_cell) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_last  = 1'b1;
                    n_m_kind  = r_pend_v ? KIND_FIRED : KIND_NONE;
                    n_m_idx   = r_pend_v ? r_pend_idx : '0;
                    n_m_hdl   = r_pend_v ? r_pend_hdl : '0;
                    n_pend_v  = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            S_SRCH: begin
                if (w_match || w_last_cell) begin
                    if (w_out_free) begin
                        w_ctl.halt     = 1'b1;
                        w_ctl.srch_upd = w_match;
                        n_m_valid = 1'b1;
                        n_m_last  = 1'b1;
                        n_m_hdl   = '0;
                        n_m_kind  = w_match ? KIND_FOUND : KIND_INVALID;
                        n_m_idx   = w_match ? IDX_OUT_W'(r_idx) : '0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    w_ctl.advance = 1'b1;
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend_v  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend_v  <= n_pend_v;
            r_m_valid <= n_m_valid;
        end
        r_idx      <= n_idx;
        r_mode     <= n_mode;
        r_id       <= n_id;
        r_pend_idx <= n_pend_idx;
        r_pend_hdl <= n_pend_hdl;
        r_m_kind   <= n_m_kind;
        r_m_idx    <= n_m_idx;
        r_m_hdl    <= n_m_hdl;
        r_m_last   <= n_m_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'b0, r_m_hdl, r_m_idx};
    assign o_m_tuser  = r_m_kind;
    assign o_m_tlast  = r_m_last;

    a_tok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("scan token held by more than one cell");

    a_nonlast_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tuser == KIND_FIRED))
        else $error("non-final result word is not a fire result");

    a_tick_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_in_mode == MODE_TICK)) |=> (r_m_valid && r_m_last))
        else $error("tick word did not produce its result");

    a_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (w_tok == '0) || (r_state != S_IDLE))
        else $error("token left in the row after a scan");

endmodule

// ===== bench/timer_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for periodic_timer_table_core: watches both stream channels, predicts
// the result words of each accepted input word and compares them in order.
// Depends on ptt_pkg only.
module timer_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,   // handler_id, slot, period, start_delay, single_shot
    input  logic [2:0]  i_s_tuser,   // mode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // found_index, fired_handler
    input  logic [2:0]  i_m_tuser,   // kind
    input  logic        i_m_tlast,   // last
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_fires
);
    import ptt_pkg::*;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] index;
        logic [7:0] handler;
        logic       last;
    } t_timer_result;

    t_timer_result expected_q[$];

    logic [HID_W-1:0]    tbl_handler  [ENTRIES_DEF];
    logic [IN_CNT_W-1:0] tbl_interval [ENTRIES_DEF];
    logic [IN_CNT_W-1:0] tbl_delay    [ENTRIES_DEF];
    logic [FLAG_W-1:0]   tbl_flags    [ENTRIES_DEF];

    int fail_n    = 0;
    int pending_n = 0;
    int results_n = 0;
    int fires_n   = 0;

    assign o_fail_count = fail_n;
    assign o_pending    = pending_n;
    assign o_results    = results_n;
    assign o_fires      = fires_n;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_n++;
    endtask

    function automatic void expect_result(input logic [2:0] kind, input logic [2:0] index,
                                          input logic [7:0] handler, input logic last);
        t_timer_result r;
        r.kind    = kind;
        r.index   = index;
        r.handler = handler;
        r.last    = last;
        expected_q.push_back(r);
    endfunction

    task automatic predict_word(input logic [47:0] w, input logic [2:0] sel);
        logic [2:0]          mode;
        logic [HID_W-1:0]    hid;
        logic [SLOT_W-1:0]   slot;
        logic [IN_CNT_W-1:0] period;
        logic [IN_CNT_W-1:0] sdelay;
        logic                one_shot;
        logic [7:0]          fire_mask;
        int                  hit;
        mode     = sel;
        hid      = w[7:0];
        slot     = w[10:8];
        period   = w[26:11];
        sdelay   = w[42:27];
        one_shot = w[43];
        case (mode)
            MODE_TICK: begin
                for (int i = 0; i < ENTRIES_DEF; i++)
                    if (tbl_flags[i][FL_RUNNABLE] && tbl_delay[i] != 0)
                        tbl_delay[i] = tbl_delay[i] - 1'b1;
                expect_result(KIND_ACK, 3'd0, 8'd0, 1'b1);
            end
            MODE_DISPATCH: begin
                fire_mask = '0;
                for (int i = 0; i < ENTRIES_DEF; i++)
                    fire_mask[i] = tbl_flags[i][FL_RUNNABLE] && tbl_delay[i] == 0;
                if (fire_mask == 0)
                    expect_result(KIND_NONE, 3'd0, 8'd0, 1'b1);
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (fire_mask[i]) begin
                        expect_result(KIND_FIRED, 3'(i), tbl_handler[i],
                                      (fire_mask >> (i + 1)) == 0);
                        if (tbl_flags[i][FL_ONESHOT]) begin
                            tbl_delay[i] = '0;
                            tbl_flags[i] = '0;
                            tbl_flags[i][FL_DELETED] = 1'b1;
                        end else begin
                            tbl_delay[i] = tbl_interval[i];
                        end
                    end
                end
            end
            MODE_SUSPEND, MODE_RESUME, MODE_RESET: begin
                hit = -1;
                for (int i = ENTRIES_DEF - 1; i >= 0; i--)
                    if (tbl_flags[i][FL_LOADED] && tbl_handler[i] == hid)
                        hit = i;
                if (hit < 0) begin
                    expect_result(KIND_INVALID, 3'd0, 8'd0, 1'b1);
                end else begin
                    if (mode == MODE_SUSPEND) begin
                        tbl_flags[hit][FL_RUNNABLE]  = 1'b0;
                        tbl_flags[hit][FL_SUSPENDED] = 1'b1;
                    end else begin
                        if (mode == MODE_RESET)
                            tbl_delay[hit] = tbl_interval[hit];
                        tbl_flags[hit][FL_SUSPENDED] = 1'b0;
                        tbl_flags[hit][FL_RUNNABLE]  = 1'b1;
                    end
                    expect_result(KIND_FOUND, 3'(hit), 8'd0, 1'b1);
                end
            end
            MODE_LOAD: begin
                tbl_handler[slot]  = hid;
                tbl_interval[slot] = period;
                tbl_delay[slot]    = sdelay;
                tbl_flags[slot]    = '0;
                tbl_flags[slot][FL_LOADED]  = 1'b1;
                tbl_flags[slot][FL_RUNNABLE] = 1'b1;
                tbl_flags[slot][FL_ONESHOT] = one_shot;
                expect_result(KIND_ACK, slot, 8'd0, 1'b1);
            end
            default: expect_result(KIND_INVALID, 3'd0, 8'd0, 1'b1);
        endcase
    endtask

    task automatic check_result();
        t_timer_result want;
        results_n++;
        if (i_m_tuser == KIND_FIRED)
            fires_n++;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result word with nothing expected, kind %0d index %0d",
                                      i_m_tuser, i_m_tdata[2:0]));
            return;
        end
        want = expected_q.pop_front();
        if (i_m_tuser !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", i_m_tuser, want.kind));
        if (i_m_tdata[2:0] !== want.index)
            report_mismatch($sformatf("found_index %0d, expected %0d",
                                      i_m_tdata[2:0], want.index));
        if (i_m_tdata[10:3] !== want.handler)
            report_mismatch($sformatf("fired_handler %02h, expected %02h",
                                      i_m_tdata[10:3], want.handler));
        if (i_m_tlast !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", i_m_tlast, want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES_DEF; i++) begin
                tbl_handler[i]  = '0;
                tbl_interval[i] = '0;
                tbl_delay[i]    = '0;
                tbl_flags[i]    = '0;
            end
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready)
                predict_word(i_s_tdata, i_s_tuser);
        end
        pending_n = expected_q.size();
    end

endmodule

// ===== bench/periodic_timer_table_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top for periodic_timer_table_core: drives directed and random words
// with random gaps and output stalls, and gives the verdict.
// Depends on ptt_pkg, periodic_timer_table_core and timer_table_checker.
module periodic_timer_table_core_test;
    import ptt_pkg::*;

    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam int RANDOM_WORDS = 180;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;
    int result_count;
    int fire_count;

    int   words_sent   = 0;
    int   directed_n   = 0;
    int   burst_left   = 0;
    logic no_idle      = 1'b0;
    logic hold_request = 1'b0;

    logic [7:0] id_pool [8] = '{8'h00, 8'hFF, 8'h11, 8'h5A, 8'hA5, 8'h3C, 8'h81, 8'h7E};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    periodic_timer_table_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    timer_table_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (result_count),
        .o_fires      (fire_count)
    );

    // word layout: mode in [2:0], tdata in [50:3]
    function automatic logic [50:0] make_word(input logic [2:0] mode, input logic [7:0] hid,
                                              input logic [2:0] slot, input logic [15:0] period,
                                              input logic [15:0] sdelay, input logic one_shot);
        return {4'b0, one_shot, sdelay, period, slot, hid, mode};
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_left > 0 || no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [50:0] random_word();
        int          r;
        logic [2:0]  mode;
        logic [7:0]  hid;
        logic [15:0] period;
        logic [15:0] sdelay;
        r = $urandom_range(0, 99);
        if (r < 30)      mode = MODE_TICK;
        else if (r < 52) mode = MODE_DISPATCH;
        else if (r < 72) mode = MODE_LOAD;
        else if (r < 79) mode = MODE_SUSPEND;
        else if (r < 87) mode = MODE_RESUME;
        else if (r < 96) mode = MODE_RESET;
        else if (r < 98) mode = MODE_SPARE_A;
        else             mode = MODE_SPARE_B;
        hid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : id_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 9) == 0) begin
            period = 16'($urandom);
            sdelay = 16'($urandom);
        end else begin
            period = 16'($urandom_range(0, 4));
            sdelay = 16'($urandom_range(0, 4));
        end
        return make_word(mode, hid, 3'($urandom), period, sdelay, 1'($urandom));
    endfunction

    task automatic send_word(input logic [50:0] w);
        int gap;
        gap = pick_gap();
        if (burst_left > 0)
            burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w[2:0];
        s_tdata  <= w[50:3];
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    initial begin : sink
        int   r;
        int   len;
        logic ready;
        wait (rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                ready = 1'b0;
                len   = HOLD_CYCLES;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    ready = 1'b1;
                    len   = $urandom_range(1, 6);
                end else if (r < 85) begin
                    ready = 1'b0;
                    len   = $urandom_range(1, 3);
                end else if (r < 95) begin
                    ready = 1'b0;
                    len   = $urandom_range(4, 12);
                end else if (r < 98) begin
                    ready = 1'b0;
                    len   = $urandom_range(20, 60);
                end else begin
                    ready = 1'b1;
                    len   = $urandom_range(40, 80);
                end
            end
            m_tready <= ready;
            repeat (len) @(posedge clk);
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d result words still expected", pending);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_word(make_word(MODE_TICK, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_DISPATCH, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_SUSPEND, 8'h5A, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_SPARE_A, 8'hFF, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1));
        send_word(make_word(MODE_SPARE_B, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_LOAD, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_LOAD, 8'hFF, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1));
        send_word(make_word(MODE_LOAD, 8'h5A, 3'd3, 16'h0002, 16'h0001, 1'b1));
        send_word(make_word(MODE_DISPATCH, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_TICK, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_DISPATCH, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_RESUME, 8'h5A, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_SUSPEND, 8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_TICK, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_RESUME, 8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_RESET, 8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_LOAD, 8'h00, 3'd1, 16'h0003, 16'h0003, 1'b0));
        send_word(make_word(MODE_SUSPEND, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_DISPATCH, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_LOAD, 8'hA5, 3'd3, 16'h0001, 16'h0000, 1'b0));
        for (int k = 0; k < ENTRIES_DEF; k++)
            send_word(make_word(MODE_LOAD, 8'(k * 37), 3'(k), 16'(k), 16'h0000, k[0]));
        send_word(make_word(MODE_DISPATCH, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        send_word(make_word(MODE_DISPATCH, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0));
        directed_n = words_sent;

        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k == 40) begin
                hold_request = 1'b1;
                burst_left   = 40;
            end
            no_idle = (k >= 120 && k < 150);
            send_word(random_word());
        end
        s_tvalid <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input words (%0d directed), %0d result words, %0d timer fires,",
                 words_sent, directed_n, result_count, fire_count);
        $display("including a %0d-cycle output hold-off under a back-to-back burst.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
